### src/fmh_pkg.sv
package fmh_pkg;

  localparam int unsigned LookaheadBits = 13;

  typedef enum logic [1:0] {
    K_ERR  = 2'd0,
    K_EOL  = 2'd1,
    K_MAKE = 2'd2,
    K_TERM = 2'd3
  } code_kind_t;

  typedef enum logic [1:0] {
    EV_SPAN  = 2'd0,
    EV_EOL   = 2'd1,
    EV_ERROR = 2'd2,
    EV_FULL  = 2'd3
  } event_kind_t;

  typedef enum logic [1:0] {
    CFG_BIT_REVERSE = 2'd0,
    CFG_HIGH_RES    = 2'd1,
    CFG_LINE_WIDTH  = 2'd2,
    CFG_PAGE_LINES  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    code_kind_t  kind;
    logic [3:0]  len;
    logic [11:0] run;
  } code_ent_t;

  typedef struct packed {
    event_kind_t kind;
    logic [11:0] row;
    logic [11:0] span_start;
    logic [11:0] span_end;
  } evt_t;

  typedef struct packed {
    logic       bit_reverse;
    logic       high_resolution;
    logic [11:0] line_width;
    logic [11:0] page_lines;
  } cfg_t;

  function automatic code_ent_t mk(input code_kind_t k, input int unsigned l,
                                   input int unsigned r);
    code_ent_t e;
    e.kind = k;
    e.len  = l[3:0];
    e.run  = r[11:0];
    return e;
  endfunction

  // make-up codes above 1728, common to both colours, plus EOL
  function automatic code_ent_t ext_entry(input logic [12:0] idx);
    code_ent_t e;
    e = mk(K_ERR, 1, 0);
    casez (idx)
      13'b00000001000??: e = mk(K_MAKE, 11, 1792);
      13'b00000001100??: e = mk(K_MAKE, 11, 1856);
      13'b00000001101??: e = mk(K_MAKE, 11, 1920);
      13'b000000010010?: e = mk(K_MAKE, 12, 1984);
      13'b000000010011?: e = mk(K_MAKE, 12, 2048);
      13'b000000010100?: e = mk(K_MAKE, 12, 2112);
      13'b000000010101?: e = mk(K_MAKE, 12, 2176);
      13'b000000010110?: e = mk(K_MAKE, 12, 2240);
      13'b000000010111?: e = mk(K_MAKE, 12, 2304);
      13'b000000011100?: e = mk(K_MAKE, 12, 2368);
      13'b000000011101?: e = mk(K_MAKE, 12, 2432);
      13'b000000011110?: e = mk(K_MAKE, 12, 2496);
      13'b000000011111?: e = mk(K_MAKE, 12, 2560);
      13'b000000000001?: e = mk(K_EOL, 12, 0);
      default: e = mk(K_ERR, 1, 0);
    endcase
    return e;
  endfunction

  function automatic code_ent_t white_entry(input logic [12:0] idx);
    code_ent_t e;
    e = ext_entry(idx);
    casez (idx)
      13'b00110101?????: e = mk(K_TERM, 8, 0);
      13'b000111???????: e = mk(K_TERM, 6, 1);
      13'b0111?????????: e = mk(K_TERM, 4, 2);
      13'b1000?????????: e = mk(K_TERM, 4, 3);
      13'b1011?????????: e = mk(K_TERM, 4, 4);
      13'b1100?????????: e = mk(K_TERM, 4, 5);
      13'b1110?????????: e = mk(K_TERM, 4, 6);
      13'b1111?????????: e = mk(K_TERM, 4, 7);
      13'b10011????????: e = mk(K_TERM, 5, 8);
      13'b10100????????: e = mk(K_TERM, 5, 9);
      13'b00111????????: e = mk(K_TERM, 5, 10);
      13'b01000????????: e = mk(K_TERM, 5, 11);
      13'b001000???????: e = mk(K_TERM, 6, 12);
      13'b000011???????: e = mk(K_TERM, 6, 13);
      13'b110100???????: e = mk(K_TERM, 6, 14);
      13'b110101???????: e = mk(K_TERM, 6, 15);
      13'b101010???????: e = mk(K_TERM, 6, 16);
      13'b101011???????: e = mk(K_TERM, 6, 17);
      13'b0100111??????: e = mk(K_TERM, 7, 18);
      13'b0001100??????: e = mk(K_TERM, 7, 19);
      13'b0001000??????: e = mk(K_TERM, 7, 20);
      13'b0010111??????: e = mk(K_TERM, 7, 21);
      13'b0000011??????: e = mk(K_TERM, 7, 22);
      13'b0000100??????: e = mk(K_TERM, 7, 23);
      13'b0101000??????: e = mk(K_TERM, 7, 24);
      13'b0101011??????: e = mk(K_TERM, 7, 25);
      13'b0010011??????: e = mk(K_TERM, 7, 26);
      13'b0100100??????: e = mk(K_TERM, 7, 27);
      13'b0011000??????: e = mk(K_TERM, 7, 28);
      13'b00000010?????: e = mk(K_TERM, 8, 29);
      13'b00000011?????: e = mk(K_TERM, 8, 30);
      13'b00011010?????: e = mk(K_TERM, 8, 31);
      13'b00011011?????: e = mk(K_TERM, 8, 32);
      13'b00010010?????: e = mk(K_TERM, 8, 33);
      13'b00010011?????: e = mk(K_TERM, 8, 34);
      13'b00010100?????: e = mk(K_TERM, 8, 35);
      13'b00010101?????: e = mk(K_TERM, 8, 36);
      13'b00010110?????: e = mk(K_TERM, 8, 37);
      13'b00010111?????: e = mk(K_TERM, 8, 38);
      13'b00101000?????: e = mk(K_TERM, 8, 39);
      13'b00101001?????: e = mk(K_TERM, 8, 40);
      13'b00101010?????: e = mk(K_TERM, 8, 41);
      13'b00101011?????: e = mk(K_TERM, 8, 42);
      13'b00101100?????: e = mk(K_TERM, 8, 43);
      13'b00101101?????: e = mk(K_TERM, 8, 44);
      13'b00000100?????: e = mk(K_TERM, 8, 45);
      13'b00000101?????: e = mk(K_TERM, 8, 46);
      13'b00001010?????: e = mk(K_TERM, 8, 47);
      13'b00001011?????: e = mk(K_TERM, 8, 48);
      13'b01010010?????: e = mk(K_TERM, 8, 49);
      13'b01010011?????: e = mk(K_TERM, 8, 50);
      13'b01010100?????: e = mk(K_TERM, 8, 51);
      13'b01010101?????: e = mk(K_TERM, 8, 52);
      13'b00100100?????: e = mk(K_TERM, 8, 53);
      13'b00100101?????: e = mk(K_TERM, 8, 54);
      13'b01011000?????: e = mk(K_TERM, 8, 55);
      13'b01011001?????: e = mk(K_TERM, 8, 56);
      13'b01011010?????: e = mk(K_TERM, 8, 57);
      13'b01011011?????: e = mk(K_TERM, 8, 58);
      13'b01001010?????: e = mk(K_TERM, 8, 59);
      13'b01001011?????: e = mk(K_TERM, 8, 60);
      13'b00110010?????: e = mk(K_TERM, 8, 61);
      13'b00110011?????: e = mk(K_TERM, 8, 62);
      13'b00110100?????: e = mk(K_TERM, 8, 63);
      13'b11011????????: e = mk(K_MAKE, 5, 64);
      13'b10010????????: e = mk(K_MAKE, 5, 128);
      13'b010111???????: e = mk(K_MAKE, 6, 192);
      13'b0110111??????: e = mk(K_MAKE, 7, 256);
      13'b00110110?????: e = mk(K_MAKE, 8, 320);
      13'b00110111?????: e = mk(K_MAKE, 8, 384);
      13'b01100100?????: e = mk(K_MAKE, 8, 448);
      13'b01100101?????: e = mk(K_MAKE, 8, 512);
      13'b01101000?????: e = mk(K_MAKE, 8, 576);
      13'b01100111?????: e = mk(K_MAKE, 8, 640);
      13'b011001100????: e = mk(K_MAKE, 9, 704);
      13'b011001101????: e = mk(K_MAKE, 9, 768);
      13'b011010010????: e = mk(K_MAKE, 9, 832);
      13'b011010011????: e = mk(K_MAKE, 9, 896);
      13'b011010100????: e = mk(K_MAKE, 9, 960);
      13'b011010101????: e = mk(K_MAKE, 9, 1024);
      13'b011010110????: e = mk(K_MAKE, 9, 1088);
      13'b011010111????: e = mk(K_MAKE, 9, 1152);
      13'b011011000????: e = mk(K_MAKE, 9, 1216);
      13'b011011001????: e = mk(K_MAKE, 9, 1280);
      13'b011011010????: e = mk(K_MAKE, 9, 1344);
      13'b011011011????: e = mk(K_MAKE, 9, 1408);
      13'b010011000????: e = mk(K_MAKE, 9, 1472);
      13'b010011001????: e = mk(K_MAKE, 9, 1536);
      13'b010011010????: e = mk(K_MAKE, 9, 1600);
      13'b011000???????: e = mk(K_MAKE, 6, 1664);
      13'b010011011????: e = mk(K_MAKE, 9, 1728);
      default: ;
    endcase
    return e;
  endfunction

  function automatic code_ent_t black_entry(input logic [12:0] idx);
    code_ent_t e;
    e = ext_entry(idx);
    casez (idx)
      13'b0000110111???: e = mk(K_TERM, 10, 0);
      13'b010??????????: e = mk(K_TERM, 3, 1);
      13'b11???????????: e = mk(K_TERM, 2, 2);
      13'b10???????????: e = mk(K_TERM, 2, 3);
      13'b011??????????: e = mk(K_TERM, 3, 4);
      13'b0011?????????: e = mk(K_TERM, 4, 5);
      13'b0010?????????: e = mk(K_TERM, 4, 6);
      13'b00011????????: e = mk(K_TERM, 5, 7);
      13'b000101???????: e = mk(K_TERM, 6, 8);
      13'b000100???????: e = mk(K_TERM, 6, 9);
      13'b0000100??????: e = mk(K_TERM, 7, 10);
      13'b0000101??????: e = mk(K_TERM, 7, 11);
      13'b0000111??????: e = mk(K_TERM, 7, 12);
      13'b00000100?????: e = mk(K_TERM, 8, 13);
      13'b00000111?????: e = mk(K_TERM, 8, 14);
      13'b000011000????: e = mk(K_TERM, 9, 15);
      13'b0000010111???: e = mk(K_TERM, 10, 16);
      13'b0000011000???: e = mk(K_TERM, 10, 17);
      13'b0000001000???: e = mk(K_TERM, 10, 18);
      13'b00001100111??: e = mk(K_TERM, 11, 19);
      13'b00001101000??: e = mk(K_TERM, 11, 20);
      13'b00001101100??: e = mk(K_TERM, 11, 21);
      13'b00000110111??: e = mk(K_TERM, 11, 22);
      13'b00000101000??: e = mk(K_TERM, 11, 23);
      13'b00000010111??: e = mk(K_TERM, 11, 24);
      13'b00000011000??: e = mk(K_TERM, 11, 25);
      13'b000011001010?: e = mk(K_TERM, 12, 26);
      13'b000011001011?: e = mk(K_TERM, 12, 27);
      13'b000011001100?: e = mk(K_TERM, 12, 28);
      13'b000011001101?: e = mk(K_TERM, 12, 29);
      13'b000001101000?: e = mk(K_TERM, 12, 30);
      13'b000001101001?: e = mk(K_TERM, 12, 31);
      13'b000001101010?: e = mk(K_TERM, 12, 32);
      13'b000001101011?: e = mk(K_TERM, 12, 33);
      13'b000011010010?: e = mk(K_TERM, 12, 34);
      13'b000011010011?: e = mk(K_TERM, 12, 35);
      13'b000011010100?: e = mk(K_TERM, 12, 36);
      13'b000011010101?: e = mk(K_TERM, 12, 37);
      13'b000011010110?: e = mk(K_TERM, 12, 38);
      13'b000011010111?: e = mk(K_TERM, 12, 39);
      13'b000001101100?: e = mk(K_TERM, 12, 40);
      13'b000001101101?: e = mk(K_TERM, 12, 41);
      13'b000011011010?: e = mk(K_TERM, 12, 42);
      13'b000011011011?: e = mk(K_TERM, 12, 43);
      13'b000001010100?: e = mk(K_TERM, 12, 44);
      13'b000001010101?: e = mk(K_TERM, 12, 45);
      13'b000001010110?: e = mk(K_TERM, 12, 46);
      13'b000001010111?: e = mk(K_TERM, 12, 47);
      13'b000001100100?: e = mk(K_TERM, 12, 48);
      13'b000001100101?: e = mk(K_TERM, 12, 49);
      13'b000001010010?: e = mk(K_TERM, 12, 50);
      13'b000001010011?: e = mk(K_TERM, 12, 51);
      13'b000000100100?: e = mk(K_TERM, 12, 52);
      13'b000000110111?: e = mk(K_TERM, 12, 53);
      13'b000000111000?: e = mk(K_TERM, 12, 54);
      13'b000000100111?: e = mk(K_TERM, 12, 55);
      13'b000000101000?: e = mk(K_TERM, 12, 56);
      13'b000001011000?: e = mk(K_TERM, 12, 57);
      13'b000001011001?: e = mk(K_TERM, 12, 58);
      13'b000000101011?: e = mk(K_TERM, 12, 59);
      13'b000000101100?: e = mk(K_TERM, 12, 60);
      13'b000001011010?: e = mk(K_TERM, 12, 61);
      13'b000001100110?: e = mk(K_TERM, 12, 62);
      13'b000001100111?: e = mk(K_TERM, 12, 63);
      13'b0000001111???: e = mk(K_MAKE, 10, 64);
      13'b000011001000?: e = mk(K_MAKE, 12, 128);
      13'b000011001001?: e = mk(K_MAKE, 12, 192);
      13'b000001011011?: e = mk(K_MAKE, 12, 256);
      13'b000000110011?: e = mk(K_MAKE, 12, 320);
      13'b000000110100?: e = mk(K_MAKE, 12, 384);
      13'b000000110101?: e = mk(K_MAKE, 12, 448);
      13'b0000001101100: e = mk(K_MAKE, 13, 512);
      13'b0000001101101: e = mk(K_MAKE, 13, 576);
      13'b0000001001010: e = mk(K_MAKE, 13, 640);
      13'b0000001001011: e = mk(K_MAKE, 13, 704);
      13'b0000001001100: e = mk(K_MAKE, 13, 768);
      13'b0000001001101: e = mk(K_MAKE, 13, 832);
      13'b0000001110010: e = mk(K_MAKE, 13, 896);
      13'b0000001110011: e = mk(K_MAKE, 13, 960);
      13'b0000001110100: e = mk(K_MAKE, 13, 1024);
      13'b0000001110101: e = mk(K_MAKE, 13, 1088);
      13'b0000001110110: e = mk(K_MAKE, 13, 1152);
      13'b0000001110111: e = mk(K_MAKE, 13, 1216);
      13'b0000001010010: e = mk(K_MAKE, 13, 1280);
      13'b0000001010011: e = mk(K_MAKE, 13, 1344);
      13'b0000001010100: e = mk(K_MAKE, 13, 1408);
      13'b0000001010101: e = mk(K_MAKE, 13, 1472);
      13'b0000001011010: e = mk(K_MAKE, 13, 1536);
      13'b0000001011011: e = mk(K_MAKE, 13, 1600);
      13'b0000001100100: e = mk(K_MAKE, 13, 1664);
      13'b0000001100101: e = mk(K_MAKE, 13, 1728);
      default: ;
    endcase
    return e;
  endfunction

endpackage

### src/fmh_front.sv
// Byte intake: optional bit reversal, then a two-entry queue to the decoder
module fmh_front (
  input  logic       clk,
  input  logic       rst,
  input  logic       bit_reverse,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] code_byte,
  output logic       q_valid,
  output logic [7:0] q_byte,
  input  logic       q_pop
);

  logic [7:0] slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic [7:0] rev_byte;
  logic       push;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rev_byte[i] = code_byte[7 - i];
    end
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_byte   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= bit_reverse ? rev_byte : code_byte;
        wr_ptr       <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

### src/fmh_back.sv
// Decoder: bit window, run-code lookup, row and page bookkeeping, event output
module fmh_back #(
  parameter int unsigned WINDOW_BITS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  fmh_pkg::cfg_t cfg,
  input  logic         q_valid,
  input  logic [7:0]   q_byte,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [1:0]   event_kind,
  output logic [11:0]  row,
  output logic [11:0]  span_start,
  output logic [11:0]  span_end,
  output logic         last
);

  localparam int unsigned UsedW  = $clog2(WINDOW_BITS + 1);
  localparam int unsigned Slack  = WINDOW_BITS - fmh_pkg::LookaheadBits;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_END,
    ST_FULL
  } state_t;

  typedef enum logic [1:0] {
    MD_SYNC,
    MD_DECODE,
    MD_DONE
  } mode_t;

  state_t                   state;
  mode_t                    mode;
  logic [WINDOW_BITS-1:0]   bit_window;
  logic [UsedW-1:0]         bits_used;
  logic                     colour_is_black;
  logic [12:0]              column;
  logic [12:0]              black_start;
  logic [12:0]              coded_line;
  logic                     end_to_sync;
  fmh_pkg::event_kind_t     end_kind;
  fmh_pkg::evt_t            pend;
  logic                     pend_v;
  fmh_pkg::evt_t            out_evt;

  logic                     slot_free;
  logic                     have_bits;
  logic [12:0]              idx;
  fmh_pkg::code_ent_t       ent;
  logic [12:0]              col_next;
  logic [12:0]              span_e;
  logic [11:0]              cur_row;
  logic [12:0]              line_next;
  logic [12:0]              limit;
  logic [11:0]              pl_eff;
  logic [UsedW-1:0]         used_clamp;
  logic [UsedW-1:0]         used_load;
  logic [UsedW-1:0]         shamt;
  logic                     out_load;

  assign slot_free = !out_valid || out_ready;
  assign have_bits = (bits_used <= UsedW'(Slack));
  assign shamt     = UsedW'(Slack) - bits_used;
  assign idx       = 13'(bit_window >> shamt);
  assign ent       = colour_is_black ? fmh_pkg::black_entry(idx) : fmh_pkg::white_entry(idx);
  assign col_next  = column + {1'b0, ent.run};
  assign span_e    = (col_next < {1'b0, cfg.line_width}) ? col_next : {1'b0, cfg.line_width};
  assign cur_row   = cfg.high_resolution ? coded_line[12:1] : coded_line[11:0];
  assign line_next = coded_line + 13'd1;
  assign pl_eff    = (cfg.page_lines == 12'd0) ? 12'd1 : cfg.page_lines;
  assign limit     = cfg.high_resolution ? {pl_eff, 1'b0} : {1'b0, pl_eff};
  assign used_clamp = (bits_used > UsedW'(WINDOW_BITS)) ? UsedW'(WINDOW_BITS) : bits_used;
  assign used_load  = (used_clamp >= UsedW'(8)) ? used_clamp - UsedW'(8) : '0;
  assign q_pop      = (state == ST_IDLE) && q_valid;

  // the held event moves to the output register this cycle
  assign out_load = slot_free && pend_v && (
                      (state == ST_DEC && (mode == MD_DONE || !have_bits)) ||
                      (state == ST_DEC && mode == MD_DECODE && have_bits &&
                       ent.kind == fmh_pkg::K_TERM && colour_is_black &&
                       span_e > black_start) ||
                      state == ST_END || state == ST_FULL);

  assign event_kind = out_evt.kind;
  assign row        = out_evt.row;
  assign span_start = out_evt.span_start;
  assign span_end   = out_evt.span_end;

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer: one byte at a time, one code, one searched bit or one event per cycle while the output slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      mode            <= MD_SYNC;
      bit_window      <= '0;
      bits_used       <= UsedW'(WINDOW_BITS);
      colour_is_black <= 1'b0;
      column          <= '0;
      black_start     <= '0;
      coded_line      <= '0;
      pend_v          <= 1'b0;
      last            <= 1'b0;
      end_to_sync     <= 1'b0;
      end_kind        <= fmh_pkg::EV_EOL;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid && mode != MD_DONE) begin
            bit_window <= WINDOW_BITS'({bit_window, q_byte});
            bits_used  <= used_load;
            state      <= ST_DEC;
          end
        end
        ST_DEC: begin
          if (mode == MD_DONE || !have_bits) begin
            // byte done: the held event goes out marked last
            if (!pend_v) begin
              state <= ST_IDLE;
            end else if (slot_free) begin
              out_evt   <= pend;
              last      <= 1'b1;
              pend_v    <= 1'b0;
              state     <= ST_IDLE;
            end
          end else if (slot_free) begin
            if (mode == MD_SYNC) begin
              if (idx[12:1] == 12'd1) begin
                bits_used       <= bits_used + UsedW'(12);
                mode            <= MD_DECODE;
                colour_is_black <= 1'b0;
                column          <= '0;
                black_start     <= '0;
              end else begin
                bits_used <= bits_used + UsedW'(1);
              end
            end else begin
              column    <= col_next;
              bits_used <= bits_used + UsedW'(ent.len);
              case (ent.kind)
                fmh_pkg::K_EOL: begin
                  end_kind    <= fmh_pkg::EV_EOL;
                  end_to_sync <= 1'b0;
                  state       <= ST_END;
                end
                fmh_pkg::K_ERR: begin
                  end_kind    <= fmh_pkg::EV_ERROR;
                  end_to_sync <= 1'b1;
                  state       <= ST_END;
                end
                default: begin
                  if (ent.kind == fmh_pkg::K_TERM) begin
                    if (!colour_is_black) begin
                      black_start <= col_next;
                    end else if (span_e > black_start) begin
                      if (pend_v) begin
                        out_evt   <= pend;
                        last      <= 1'b0;
                      end
                      pend.kind       <= fmh_pkg::EV_SPAN;
                      pend.row        <= cur_row;
                      pend.span_start <= black_start[11:0];
                      pend.span_end   <= span_e[11:0];
                      pend_v          <= 1'b1;
                    end
                    colour_is_black <= ~colour_is_black;
                  end
                  if (col_next > {1'b0, cfg.line_width}) begin
                    end_kind    <= fmh_pkg::EV_ERROR;
                    end_to_sync <= 1'b1;
                    state       <= ST_END;
                  end
                end
              endcase
            end
          end
        end
        ST_END: begin
          if (slot_free) begin
            if (pend_v) begin
              out_evt   <= pend;
              last      <= 1'b0;
            end
            pend.kind       <= end_kind;
            pend.row        <= cur_row;
            pend.span_start <= '0;
            pend.span_end   <= '0;
            pend_v          <= 1'b1;
            coded_line      <= line_next;
            colour_is_black <= 1'b0;
            column          <= '0;
            black_start     <= '0;
            mode            <= end_to_sync ? MD_SYNC : MD_DECODE;
            state           <= (line_next >= limit) ? ST_FULL : ST_DEC;
          end
        end
        ST_FULL: begin
          if (slot_free) begin
            if (pend_v) begin
              out_evt   <= pend;
              last      <= 1'b0;
            end
            pend.kind       <= fmh_pkg::EV_FULL;
            pend.row        <= cur_row;
            pend.span_start <= '0;
            pend.span_end   <= '0;
            pend_v          <= 1'b1;
            mode            <= MD_DONE;
            state           <= ST_DEC;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/fax_mh_line_decoder.sv
// One-dimensional modified Huffman fax line decoder. Coded bytes (optionally
// bit-reversed) enter through a two-entry queue; the decoder holds a
// WINDOW_BITS-bit window and decodes one run code per clock once 13 bits are
// buffered, or moves one bit per clock while hunting for EOL, as long as the
// output register is free. Each black run comes out as a row/start/end span;
// row ends (EOL or error) and page full come out as events, with last set on
// the final event of each byte. A byte is loaded into the window, its codes
// or searched bits are decoded, its row and page events are issued, and a
// closing step sends any held event; only then is the next byte taken.
// After page full every further byte is accepted and ignored.
// User must write configuration only while no byte is in flight (unenforced).
module fax_mh_line_decoder #(
  parameter int unsigned WINDOW_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  code_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic [11:0] row,
  output logic [11:0] span_start,
  output logic [11:0] span_end,
  output logic        last
);

  fmh_pkg::cfg_t cfg;
  logic          q_valid;
  logic [7:0]    q_byte;
  logic          q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_reverse     <= 1'b0;
      cfg.high_resolution <= 1'b0;
      cfg.line_width      <= 12'd1728;
      cfg.page_lines      <= 12'd1410;
    end else if (cfg_write) begin
      case (fmh_pkg::cfg_index_t'(cfg_index))
        fmh_pkg::CFG_BIT_REVERSE: cfg.bit_reverse     <= cfg_data[0];
        fmh_pkg::CFG_HIGH_RES:    cfg.high_resolution <= cfg_data[0];
        fmh_pkg::CFG_LINE_WIDTH:  cfg.line_width      <= cfg_data;
        fmh_pkg::CFG_PAGE_LINES:  cfg.page_lines      <= cfg_data;
        default: ;
      endcase
    end
  end

  fmh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .bit_reverse (cfg.bit_reverse),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .code_byte   (code_byte),
    .q_valid     (q_valid),
    .q_byte      (q_byte),
    .q_pop       (q_pop)
  );

  fmh_back #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_byte     (q_byte),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .row        (row),
    .span_start (span_start),
    .span_end   (span_end),
    .last       (last)
  );

endmodule
